FILE: sv/tcss_pkg.sv
// Shared types and constants for the two-choice subset sum core.
package tcss_pkg;

	localparam int WORD_W = 64;
	localparam int SUM_W  = 13;

	// Source of the word returned by a row read
	localparam logic [1:0] RD_MEM  = 2'd0;
	localparam logic [1:0] RD_ZERO = 2'd1;
	localparam logic [1:0] RD_ONE  = 2'd2;

	typedef struct packed {
		logic [SUM_W-1:0] heads;
		logic [SUM_W-1:0] tails;
	} card_t;

endpackage

FILE: sv/tcss_row_mem.sv
// Reachable-sum row memory: one write port, one registered read port.
module tcss_row_mem #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [tcss_pkg::WORD_W-1:0] wr_data,
	input  logic [AW-1:0]              rd_addr,
	output logic [tcss_pkg::WORD_W-1:0] rd_data
);
	import tcss_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: sv/tcss_card_store.sv
// Heads/tails value store, one entry per card, registered read.
module tcss_card_store #(
	parameter int DEPTH = 64,
	parameter int IW    = 6
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IW-1:0]         wr_addr,
	input  tcss_pkg::card_t       wr_data,
	input  logic [IW-1:0]         rd_addr,
	output tcss_pkg::card_t       rd_data
);
	import tcss_pkg::*;

	card_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: sv/tcss_funnel.sv
// Funnel shifter: upper word of {cur, prev} shifted left by amt.
module tcss_funnel (
	input  logic [tcss_pkg::WORD_W-1:0] cur,
	input  logic [tcss_pkg::WORD_W-1:0] prev,
	input  logic [5:0]                  amt,
	output logic [tcss_pkg::WORD_W-1:0] res
);
	import tcss_pkg::*;

	logic [2*WORD_W-1:0] wide;

	always_comb begin
		wide = {cur, prev} << amt;
		res  = wide[2*WORD_W-1:WORD_W];
	end

endmodule

FILE: sv/two_choice_subset_sum_core.sv
// Two-choice subset sum core: builds reachable-sum rows and backtracks a choice per card.
// For each card, every 64-bit word of the new row needs two reads of the single read port
// of the row memory (heads and tails source words), each passed through one shared funnel
// shifter, and the merged word is written while the next read goes out. On the card marked
// last the core reads the target bit for a verdict and, if the target is reachable, backtracks
// card by card; it then emits one result word per card, or a lone word when none is found.
// The block takes no new card until the last result word has been taken. Row zero is implied
// (only sum zero), so the row memory needs no clearing after reset.
module two_choice_subset_sum_core #(
	parameter int MAX_SUM   = 8191,
	parameter int MAX_ITEMS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcss_pkg::SUM_W-1:0]  cfg_wdata,   // target_sum
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,     // heads_value[12:0], tails_value[25:13]
	input  logic                        s_tlast,     // last_card
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [7:0]                  m_tdata,     // found[0], card_index[6:1], shows_tails[7]
	output logic                        m_tlast      // last_result
);
	import tcss_pkg::*;

	localparam int ROW_WORDS = MAX_SUM / 64 + 1;
	localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int RW        = $clog2(MAX_ITEMS + 1);
	localparam int IW        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int DEPTH     = MAX_ITEMS * ROW_WORDS;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOP_BITS  = MAX_SUM % 64 + 1;
	localparam logic [WORD_W-1:0] TOP_MASK =
		(TOP_BITS >= 64) ? {WORD_W{1'b1}} : ((WORD_W'(1) << TOP_BITS) - WORD_W'(1));

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_BLD_A  = 4'd1;
	localparam logic [3:0] ST_BLD_B  = 4'd2;
	localparam logic [3:0] ST_BLD_F  = 4'd3;
	localparam logic [3:0] ST_END    = 4'd4;
	localparam logic [3:0] ST_VRD    = 4'd5;
	localparam logic [3:0] ST_VCHK   = 4'd6;
	localparam logic [3:0] ST_BT_LD  = 4'd7;
	localparam logic [3:0] ST_BT_RD  = 4'd8;
	localparam logic [3:0] ST_BT_CHK = 4'd9;
	localparam logic [3:0] ST_EMIT   = 4'd10;

	logic [3:0]        state_q;
	logic [SUM_W-1:0]  tgt_q;
	logic [RW-1:0]     cnt_q;
	logic [RW-1:0]     n_q;
	logic              ovf_q;
	logic              last_q;
	logic              pend_q;
	logic              nf_q;
	logic [SUM_W-1:0]  hv_q;
	logic [SUM_W-1:0]  tv_q;
	logic [WW-1:0]     w_q;
	logic [WW-1:0]     wr_w_q;
	logic [WORD_W-1:0] h_prev_q;
	logic [WORD_W-1:0] t_prev_q;
	logic [WORD_W-1:0] h_word_q;
	logic [1:0]        rd_sel_q;
	logic [SUM_W-1:0]  s_q;
	logic [SUM_W-1:0]  d_q;
	logic [SUM_W-1:0]  b_q;
	logic              ge_q;
	logic [IW-1:0]     c_q;
	logic [IW-1:0]     e_q;
	logic [MAX_ITEMS-1:0] pick_q;
	logic              m_valid_q;
	logic              m_found_q;
	logic [IW-1:0]     m_idx_q;
	logic              m_tails_q;
	logic              m_last_q;

	logic              in_acc;
	logic              store_ok;
	logic [RW-1:0]     rd_row;
	logic [WW-1:0]     rd_word;
	logic              rd_ok;
	logic [1:0]        rd_sel_d;
	logic [AW-1:0]     mem_rd_addr;
	logic [WORD_W-1:0] mem_rd_data;
	logic              mem_wr_en;
	logic [AW-1:0]     mem_wr_addr;
	logic [WORD_W-1:0] mem_wr_data;
	logic [WORD_W-1:0] eff;
	logic [WORD_W-1:0] sh_prev;
	logic [5:0]        sh_amt;
	logic [WORD_W-1:0] sh_out;
	card_t             st_wr;
	card_t             st_rd;
	logic [SUM_W-1:0]  dsum;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign store_ok = (int'(cnt_q) < MAX_ITEMS);
	assign dsum     = s_q - st_rd.heads;

	// read request for the row memory
	always_comb begin
		rd_row  = cnt_q;
		rd_word = '0;
		rd_ok   = 1'b0;
		case (state_q)
			ST_BLD_A: begin
				rd_ok   = (int'(w_q) >= int'(hv_q[SUM_W-1:6]));
				rd_word = WW'(int'(w_q) - int'(hv_q[SUM_W-1:6]));
			end
			ST_BLD_B: begin
				rd_ok   = (int'(w_q) >= int'(tv_q[SUM_W-1:6]));
				rd_word = WW'(int'(w_q) - int'(tv_q[SUM_W-1:6]));
			end
			ST_VRD: begin
				rd_row  = n_q;
				rd_word = WW'(tgt_q >> 6);
				rd_ok   = 1'b1;
			end
			ST_BT_RD: begin
				rd_row  = RW'(c_q);
				rd_word = WW'(dsum >> 6);
				rd_ok   = 1'b1;
			end
			default: begin
				rd_ok = 1'b0;
			end
		endcase
	end

	// row zero is implied: only sum zero is set
	always_comb begin
		if (!rd_ok) begin
			rd_sel_d = RD_ZERO;
		end else if (rd_row == '0) begin
			rd_sel_d = (rd_word == '0) ? RD_ONE : RD_ZERO;
		end else begin
			rd_sel_d = RD_MEM;
		end
		mem_rd_addr = AW'((int'(rd_row) - 1) * ROW_WORDS + int'(rd_word));
	end

	always_comb begin
		case (rd_sel_q)
			RD_MEM:  eff = mem_rd_data;
			RD_ONE:  eff = WORD_W'(1);
			default: eff = '0;
		endcase
	end

	// shared shifter: heads word in BLD_B, tails word otherwise
	always_comb begin
		if (state_q == ST_BLD_B) begin
			sh_prev = h_prev_q;
			sh_amt  = hv_q[5:0];
		end else begin
			sh_prev = t_prev_q;
			sh_amt  = tv_q[5:0];
		end
	end

	tcss_funnel u_funnel (
		.cur  (eff),
		.prev (sh_prev),
		.amt  (sh_amt),
		.res  (sh_out)
	);

	// merged word write into row cnt_q+1
	always_comb begin
		mem_wr_en   = ((state_q == ST_BLD_A) && pend_q) || (state_q == ST_BLD_F);
		mem_wr_addr = AW'(int'(cnt_q) * ROW_WORDS + int'(wr_w_q));
		mem_wr_data = h_word_q | sh_out;
		if (wr_w_q == WW'(ROW_WORDS - 1)) begin
			mem_wr_data = mem_wr_data & TOP_MASK;
		end
	end

	tcss_row_mem #(.DEPTH(DEPTH), .AW(AW)) u_rows (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	assign st_wr.heads = s_tdata[SUM_W-1:0];
	assign st_wr.tails = s_tdata[2*SUM_W-1:SUM_W];

	tcss_card_store #(.DEPTH(MAX_ITEMS), .IW(IW)) u_cards (
		.clk     (clk),
		.wr_en   (in_acc && store_ok),
		.wr_addr (cnt_q[IW-1:0]),
		.wr_data (st_wr),
		.rd_addr (c_q),
		.rd_data (st_rd)
	);

	// target register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= '0;
		end else if (cfg_we) begin
			tgt_q <= cfg_wdata;
		end
	end

	// read source tag follows the memory latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_sel_q <= RD_ZERO;
		end else begin
			rd_sel_q <= rd_sel_d;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			last_q    <= 1'b0;
			pend_q    <= 1'b0;
			nf_q      <= 1'b0;
			w_q       <= '0;
			wr_w_q    <= '0;
			c_q       <= '0;
			e_q       <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						hv_q     <= s_tdata[SUM_W-1:0];
						tv_q     <= s_tdata[2*SUM_W-1:SUM_W];
						last_q   <= s_tlast;
						w_q      <= '0;
						pend_q   <= 1'b0;
						h_prev_q <= '0;
						t_prev_q <= '0;
						if (store_ok) begin
							state_q <= ST_BLD_A;
						end else begin
							ovf_q   <= 1'b1;
							state_q <= ST_END;
						end
					end
				end
				ST_BLD_A: begin
					if (pend_q) begin
						t_prev_q <= eff;
					end
					state_q <= ST_BLD_B;
				end
				ST_BLD_B: begin
					h_prev_q <= eff;
					h_word_q <= sh_out;
					pend_q   <= 1'b1;
					wr_w_q   <= w_q;
					if (w_q == WW'(ROW_WORDS - 1)) begin
						state_q <= ST_BLD_F;
					end else begin
						w_q     <= w_q + WW'(1);
						state_q <= ST_BLD_A;
					end
				end
				ST_BLD_F: begin
					cnt_q   <= cnt_q + RW'(1);
					state_q <= ST_END;
				end
				ST_END: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else begin
						n_q   <= cnt_q;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						if (!ovf_q && cnt_q != '0 && int'(tgt_q) <= MAX_SUM) begin
							state_q <= ST_VRD;
						end else begin
							nf_q    <= 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_VRD: begin
					state_q <= ST_VCHK;
				end
				ST_VCHK: begin
					if (eff[tgt_q[5:0]]) begin
						s_q     <= tgt_q;
						c_q     <= IW'(n_q - RW'(1));
						nf_q    <= 1'b0;
						state_q <= ST_BT_LD;
					end else begin
						nf_q    <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_BT_LD: begin
					state_q <= ST_BT_RD;
				end
				ST_BT_RD: begin
					d_q     <= dsum;
					ge_q    <= (s_q >= st_rd.heads);
					b_q     <= st_rd.tails;
					state_q <= ST_BT_CHK;
				end
				ST_BT_CHK: begin
					// heads wins when both faces work
					if (ge_q && eff[d_q[5:0]]) begin
						s_q         <= d_q;
						pick_q[c_q] <= 1'b0;
					end else begin
						if (s_q >= b_q) begin
							s_q <= s_q - b_q;
						end
						pick_q[c_q] <= 1'b1;
					end
					if (c_q == '0) begin
						e_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						c_q     <= c_q - IW'(1);
						state_q <= ST_BT_LD;
					end
				end
				ST_EMIT: begin
					if (!m_valid_q) begin
						m_valid_q <= 1'b1;
						m_found_q <= !nf_q;
						m_idx_q   <= nf_q ? '0 : e_q;
						m_tails_q <= !nf_q && pick_q[e_q];
						m_last_q  <= nf_q || ((RW'(e_q) + RW'(1)) == n_q);
					end else if (m_tready) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							e_q <= e_q + IW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_tails_q, 6'(m_idx_q), m_found_q};
	assign m_tlast  = m_last_q;

endmodule

FILE: sv/tcss_checker.sv
// Port-level checks for the two-choice subset sum core, bound to the top level.
module tcss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// ready is low in the cycle after every accepted card
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted word");

	// no card taken while a result word is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while a result word is pending");

	// a not-found verdict is a single word
	a_notfound_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tlast && m_tdata[7:1] == 7'd0))
		else $error("not-found word is not a lone zero word");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result word changed");

endmodule

bind two_choice_subset_sum_core tcss_checker u_tcss_checker (.*);
